/* hdl/mandelbrot_pixel_escape_macros.svh */
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_ESCAPE_MACROS_SVH
`define MANDELBROT_PIXEL_ESCAPE_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mpe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: package
// Fixed-point widths, register indexes, job and config bundles, saturation.
// ---------------------------------------------------------------------------
package mpe_pkg;

  // Field widths
  localparam int COORD_W   = 12;
  localparam int WORD_W    = 32;
  localparam int PITCH_W   = 31;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Fixed-point format and derived constants
  localparam int FRAC_BITS    = 28;
  localparam int PALETTE_SIZE = 16;
  localparam int PALETTE_W    = $clog2(PALETTE_SIZE);
  localparam int PROD_W       = COORD_W + PITCH_W;
  localparam int SAT_W        = PROD_W + 3;
  // |z|^2 >= 4 in Q(2*FRAC_BITS) means bit 2*FRAC_BITS+2 or above is set
  localparam int ESC_BIT      = 2 * FRAC_BITS + 2;

  // Register reset values
  localparam logic [COUNT_W-1:0]       LIMIT_RST  = 16'd256;
  localparam logic [COUNT_W-1:0]       OFFSET_RST = 16'd0;
  localparam logic signed [WORD_W-1:0] LEFT_RST   = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] TOP_RST    = 32'sd268435456;
  localparam logic [PITCH_W-1:0]       PITCH_RST  = 31'd786432;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITER_LIMIT   = 3'd0,
    REG_COLOR_OFFSET = 3'd1,
    REG_LEFT_EDGE    = 3'd2,
    REG_TOP_EDGE     = 3'd3,
    REG_COL_PITCH    = 3'd4,
    REG_ROW_PITCH    = 3'd5
  } mpe_reg_idx_t;

  // Iteration engine states
  typedef enum logic {
    CORE_IDLE,
    CORE_RUN
  } mpe_core_state_t;

  // Live configuration
  typedef struct packed {
    logic [COUNT_W-1:0]       iteration_limit;
    logic [COUNT_W-1:0]       color_offset;
    logic signed [WORD_W-1:0] left_edge;
    logic signed [WORD_W-1:0] top_edge;
    logic [PITCH_W-1:0]       column_pitch;
    logic [PITCH_W-1:0]       row_pitch;
  } mpe_cfg_t;

  // One pixel with its point c, passed from front to back
  typedef struct packed {
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [WORD_W-1:0] cx;
    logic signed [WORD_W-1:0] cy;
  } mpe_job_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat_word(
      input logic signed [SAT_W-1:0] v);
    logic [SAT_W-WORD_W:0] top_bits;
    top_bits = v[SAT_W-1:WORD_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[WORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* hdl/mpe_channels_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: channel interfaces
// Valid/ready channels for pixel requests, results and register writes.
// ---------------------------------------------------------------------------

// Pixel request channel
interface mpe_pixel_if import mpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_col;
  modport source (output valid, pixel_row, pixel_col, input ready);
  modport sink   (input valid, pixel_row, pixel_col, output ready);
endinterface

// Result channel
interface mpe_result_if import mpe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [COUNT_W-1:0]   iter_count;
  logic                 inside_set;
  logic [PALETTE_W-1:0] palette_slot;
  modport source (output valid, out_row, out_col, iter_count, inside_set,
                  palette_slot, input ready);
  modport sink   (input valid, out_row, out_col, iter_count, inside_set,
                  palette_slot, output ready);
endinterface

// Register write channel
interface mpe_cfg_if import mpe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mpe_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: front end
// Accepts pixel requests and maps row and column to the point c.
// ---------------------------------------------------------------------------
module mpe_front import mpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mpe_cfg_t  cfg,
  mpe_pixel_if.sink pixel,
  output logic      job_valid,
  input  logic      job_ready,
  output mpe_job_t  job
);

  logic               f_valid;
  logic [COORD_W-1:0] f_row;
  logic [COORD_W-1:0] f_col;
  logic [PROD_W-1:0]  f_prod_c;
  logic [PROD_W-1:0]  f_prod_r;
  logic               accept;
  logic [SAT_W-1:0]   cx_wide;
  logic [SAT_W-1:0]   cy_wide;

  // Take a new pixel when the product stage is empty or draining
  assign pixel.ready = !f_valid || job_ready;
  assign accept      = pixel.valid && pixel.ready;

  // Hold the product stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (job_ready) begin
      f_valid <= 1'b0;
    end
  end

  // Register the pitch products
  always_ff @(posedge clk) begin
    if (accept) begin
      f_row    <= pixel.pixel_row;
      f_col    <= pixel.pixel_col;
      f_prod_c <= PROD_W'(pixel.pixel_col) * PROD_W'(cfg.column_pitch);
      f_prod_r <= PROD_W'(pixel.pixel_row) * PROD_W'(cfg.row_pitch);
    end
  end

  // Offset from the edges and clamp
  always_comb begin
    cx_wide = SAT_W'(cfg.left_edge) + SAT_W'($signed({1'b0, f_prod_c}));
    cy_wide = SAT_W'(cfg.top_edge) - SAT_W'($signed({1'b0, f_prod_r}));
    job.row = f_row;
    job.col = f_col;
    job.cx  = sat_word(cx_wide);
    job.cy  = sat_word(cy_wide);
  end

  assign job_valid = f_valid;

endmodule

/* hdl/mpe_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: job queue
// Small FIFO of prepared pixels between the front end and the iteration core.
// ---------------------------------------------------------------------------
module mpe_queue import mpe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mpe_job_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mpe_job_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpe_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

/* hdl/mpe_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: iteration core
// Runs z = z*z + c one step per cycle and registers the escape result.
// ---------------------------------------------------------------------------
module mpe_core import mpe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  mpe_cfg_t      cfg,
  input  logic          job_valid,
  output logic          job_ready,
  input  mpe_job_t      job_in,
  mpe_result_if.source  result
);

  mpe_core_state_t          state;
  mpe_core_state_t          state_next;
  mpe_job_t                 job;
  logic signed [WORD_W-1:0] zr;
  logic signed [WORD_W-1:0] zi;
  logic [COUNT_W-1:0]       k;
  logic                     out_valid;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_inside;
  logic [PALETTE_W-1:0]     out_slot;

  logic signed [2*WORD_W-1:0] rr;
  logic signed [2*WORD_W-1:0] ii;
  logic signed [2*WORD_W-1:0] ri;
  logic [2*WORD_W-1:0]        mag;
  logic signed [2*WORD_W:0]   diff;
  logic signed [WORD_W-1:0]   nr;
  logic signed [WORD_W-1:0]   ni;
  logic                       escaped;
  logic                       finish;
  logic                       load_out;
  logic                       in_set;
  logic [COUNT_W:0]           slot_sum;

  // Square and cross products of the current z, then the next z
  always_comb begin
    rr       = zr * zr;
    ii       = zi * zi;
    ri       = zr * zi;
    mag      = $unsigned(rr) + $unsigned(ii);
    escaped  = |mag[2*WORD_W-1:ESC_BIT];
    diff     = {rr[2*WORD_W-1], rr} - {ii[2*WORD_W-1], ii};
    nr       = sat_word(SAT_W'($signed(diff[2*WORD_W:FRAC_BITS]))
                        + SAT_W'($signed(job.cx)));
    ni       = sat_word(SAT_W'($signed(ri[2*WORD_W-1:FRAC_BITS-1]))
                        + SAT_W'($signed(job.cy)));
    in_set   = (k == cfg.iteration_limit);
    slot_sum = {1'b0, k} + {1'b0, cfg.color_offset};
  end

  // Sequence control: load a job, iterate, retire into the output register
  always_comb begin
    job_ready  = 1'b0;
    finish     = 1'b0;
    load_out   = 1'b0;
    state_next = state;
    unique case (state)
      CORE_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = CORE_RUN;
        end
      end
      CORE_RUN: begin
        finish   = (k != '0) && (escaped || k >= cfg.iteration_limit);
        load_out = finish && (!out_valid || result.ready);
        if (load_out) begin
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a job or advance z; hold while the result waits for room
  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && job_valid) begin
      job <= job_in;
      zr  <= '0;
      zi  <= '0;
      k   <= '0;
    end else if (state == CORE_RUN && !finish) begin
      zr <= nr;
      zi <= ni;
      k  <= k + 1'b1;
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the finished pixel
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row    <= job.row;
      out_col    <= job.col;
      out_count  <= k;
      out_inside <= in_set;
      out_slot   <= in_set ? '0 : PALETTE_W'(slot_sum % PALETTE_SIZE);
    end
  end

  assign result.valid        = out_valid;
  assign result.out_row      = out_row;
  assign result.out_col      = out_col;
  assign result.iter_count   = out_count;
  assign result.inside_set   = out_inside;
  assign result.palette_slot = out_slot;

endmodule

/* hdl/mandelbrot_pixel_escape.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: top level
// Escape-time engine for one pixel at a time with a decoupled front end.
// ---------------------------------------------------------------------------
// Usage:
//   pixel  : request channel carrying pixel_row and pixel_col.
//   result : echoed row and column, iteration count, inside flag and
//            palette slot, held in an output register until taken.
//   cfg    : register writes (index, data); always ready. Write only while
//            no pixel is in flight.
// Timing:
//   The front end registers the pitch products on acceptance and offers c
//   from that product register to a two-entry queue, so requests are taken
//   while the core is busy.
//   The core loads the job, makes one z update per counted iteration and
//   then retires the pixel into the output register. With the default
//   limit of 256 an inside pixel makes 256 z updates; throughput is set
//   by this single iteration loop. On an idle engine the request passes
//   the product register, queue and core before its result is offered.
// Reset: synchronous; clears all handshake state and loads the register
//   reset values (limit 256, offset 0, view -2.0 + 1.0i, pitch 786432).
// Stall: a held result blocks the core, the queue then fills and the
//   request channel drops ready.
// ---------------------------------------------------------------------------
module mandelbrot_pixel_escape import mpe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mpe_pixel_if.sink    pixel,
  mpe_result_if.source result,
  mpe_cfg_if.sink      cfg
);

  mpe_cfg_t cfg_regs;
  logic     fq_valid;
  logic     fq_ready;
  mpe_job_t fq_job;
  logic     qc_valid;
  logic     qc_ready;
  mpe_job_t qc_job;

  assign cfg.ready = 1'b1;

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.iteration_limit <= LIMIT_RST;
      cfg_regs.color_offset    <= OFFSET_RST;
      cfg_regs.left_edge       <= LEFT_RST;
      cfg_regs.top_edge        <= TOP_RST;
      cfg_regs.column_pitch    <= PITCH_RST;
      cfg_regs.row_pitch       <= PITCH_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ITER_LIMIT:   cfg_regs.iteration_limit <= cfg.data[COUNT_W-1:0];
        REG_COLOR_OFFSET: cfg_regs.color_offset    <= cfg.data[COUNT_W-1:0];
        REG_LEFT_EDGE:    cfg_regs.left_edge       <= cfg.data;
        REG_TOP_EDGE:     cfg_regs.top_edge        <= cfg.data;
        REG_COL_PITCH:    cfg_regs.column_pitch    <= cfg.data[PITCH_W-1:0];
        REG_ROW_PITCH:    cfg_regs.row_pitch       <= cfg.data[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pixel     (pixel),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  mpe_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_job),
    .out_valid (qc_valid),
    .out_ready (qc_ready),
    .out_data  (qc_job)
  );

  mpe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .job_valid (qc_valid),
    .job_ready (qc_ready),
    .job_in    (qc_job),
    .result    (result)
  );

endmodule

/* hdl/mpe_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mandelbrot pixel escape: port checker
// Watches the result channel of the top level; bound in below.
// ---------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_macros.svh"

module mpe_checker import mpe_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COORD_W-1:0]   out_row,
  input logic [COORD_W-1:0]   out_col,
  input logic [COUNT_W-1:0]   iter_count,
  input logic                 inside_set,
  input logic [PALETTE_W-1:0] palette_slot
);

  // A stalled result stays offered and unchanged
  `MPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MPE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_row, out_col, iter_count, inside_set, palette_slot}), "result changed while stalled")

  // At least one iteration is always reported
  `MPE_ASSERT_NOW(a_count_nonzero, out_valid, iter_count != '0, "zero iteration count")

  // Inside pixels carry the black palette slot
  `MPE_ASSERT_NOW(a_inside_slot, out_valid && inside_set, palette_slot == '0, "inside pixel with nonzero slot")

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_row      (result.out_row),
  .out_col      (result.out_col),
  .iter_count   (result.iter_count),
  .inside_set   (result.inside_set),
  .palette_slot (result.palette_slot)
);
